@@ hdl/signed_unsigned_divider_32_top_macros.svh @@
// Assertion macros shared by the divider checker.
`ifndef SIGNED_UNSIGNED_DIVIDER_32_TOP_MACROS_SVH
`define SIGNED_UNSIGNED_DIVIDER_32_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SUD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SUD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/sud_pkg.sv @@
// Shared constants, types and the per-bit divide step for the divider.
package sud_pkg;

  localparam int DATA_W  = 32;
  localparam int STEPS   = DATA_W;
  // entry stage + one stage per quotient bit + output stage
  localparam int LATENCY = STEPS + 2;

  // function codes
  localparam logic [1:0] FUNC_REMU = 2'd0;
  localparam logic [1:0] FUNC_DIV  = 2'd1;
  localparam logic [1:0] FUNC_DIVU = 2'd2;
  localparam logic [1:0] FUNC_REM  = 2'd3;

  typedef logic [DATA_W-1:0] word_t;

  // payload carried by one pipeline stage
  typedef struct packed {
    word_t rem;       // partial remainder
    word_t quo;       // dividend bits shift out at top, quotient bits in at bottom
    word_t den;       // divisor magnitude
    logic  want_rem;
    logic  quo_neg;
    logic  rem_neg;
  } stage_t;

  // One restoring step: bring down a dividend bit, subtract if it fits.
  function automatic stage_t div_step(stage_t s);
    logic [DATA_W:0] shifted;
    logic [DATA_W:0] diff;
    stage_t          o;
    shifted = {s.rem, s.quo[DATA_W-1]};
    diff    = shifted - {1'b0, s.den};
    o       = s;
    if (!diff[DATA_W]) begin
      o.rem = diff[DATA_W-1:0];
      o.quo = {s.quo[DATA_W-2:0], 1'b1};
    end else begin
      o.rem = shifted[DATA_W-1:0];
      o.quo = {s.quo[DATA_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

@@ hdl/signed_unsigned_divider_32_top.sv @@
// Pipelined 32-bit signed/unsigned divide and remainder unit.
//
// Usage:
//   A word (func, dividend, divisor) is taken at a rising edge where start is
//   high and busy is low. busy never rises: a new word may be issued every cycle.
//   func: 0 unsigned remainder, 1 signed quotient, 2 unsigned quotient,
//   3 signed remainder.
//   The result appears on result with done high for exactly one cycle, once
//   the word has passed the entry stage, the restoring stages and the output
//   stage. Words come out in issue order.
//   Throughput: one word per cycle, set by a pipeline of one entry stage
//   (sign magnitudes), 32 restoring stages (one quotient bit each, a 33-bit
//   subtract per stage) and one output stage (sign correction).
//   Divide by zero gives an all-ones quotient and the dividend as remainder.
//   Reset (rst, synchronous) clears all valid bits; words in flight are dropped.
//   The receiver cannot stall: done is a strobe and result must be taken then.
module signed_unsigned_divider_32_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          func,
  input  sud_pkg::word_t      dividend,
  input  sud_pkg::word_t      divisor,
  output logic                busy,
  output logic                done,
  output sud_pkg::word_t      result
);
  import sud_pkg::*;

  // stage 0 is the entry register, stage k holds k quotient bits
  stage_t          stg [STEPS+1];
  logic [STEPS:0]  vld;

  stage_t entry_next;
  stage_t step_next [STEPS];
  word_t  res_sel;
  logic   res_neg;
  word_t  result_next;

  // pipeline never holds off input
  assign busy = 1'b0;

  // entry: sign decode and magnitudes
  always_comb begin
    logic is_signed;
    logic div_zero;
    logic a_neg;
    logic b_neg;
    is_signed = (func == FUNC_DIV) || (func == FUNC_REM);
    div_zero  = (divisor == '0);
    // divide by zero bypasses all sign handling
    a_neg = is_signed && !div_zero && dividend[DATA_W-1];
    b_neg = is_signed && !div_zero && divisor[DATA_W-1];
    entry_next.rem      = '0;
    entry_next.quo      = a_neg ? (~dividend + word_t'(1)) : dividend;
    entry_next.den      = b_neg ? (~divisor + word_t'(1)) : divisor;
    entry_next.want_rem = (func == FUNC_REMU) || (func == FUNC_REM);
    entry_next.quo_neg  = a_neg ^ b_neg;
    entry_next.rem_neg  = a_neg;
  end

  // one restoring step per stage
  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      step_next[i] = div_step(stg[i]);
    end
  end

  // output select and sign correction
  always_comb begin
    res_sel     = stg[STEPS].want_rem ? stg[STEPS].rem : stg[STEPS].quo;
    res_neg     = stg[STEPS].want_rem ? stg[STEPS].rem_neg : stg[STEPS].quo_neg;
    result_next = res_neg ? (~res_sel + word_t'(1)) : res_sel;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[STEPS-1:0], start};
      done <= vld[STEPS];
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    stg[0] <= entry_next;
    for (int i = 0; i < STEPS; i++) begin
      stg[i+1] <= step_next[i];
    end
    result <= result_next;
  end

endmodule

@@ hdl/sud_checker.sv @@
// Port-level checker for the divider, bound to the top level.
`include "signed_unsigned_divider_32_top_macros.svh"

module sud_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic [1:0]     func,
  input sud_pkg::word_t dividend,
  input sud_pkg::word_t divisor,
  input logic           busy,
  input logic           done,
  input sud_pkg::word_t result
);
  import sud_pkg::*;

  logic take;
  assign take = start && !busy;

  // every taken word yields a strobe after the fixed latency
  `SUD_ASSERT_IMPL(a_done_lat, clk, rst, take, ##LATENCY done, "missing done after a taken word")

  // no strobe without a word taken the fixed latency earlier
  `SUD_ASSERT_IMPL(a_done_src, clk, rst, done, $past(take, LATENCY), "done without a matching word")

  // unsigned quotient by zero is all ones
  `SUD_ASSERT_IMPL(a_divu_zero, clk, rst, take && (func == FUNC_DIVU) && (divisor == '0),
    ##LATENCY (result == '1), "unsigned divide by zero not all ones")

  // signed remainder by zero returns the dividend unchanged
  `SUD_ASSERT_IMPL(a_rem_zero, clk, rst, take && (func == FUNC_REM) && (divisor == '0),
    ##LATENCY (result == $past(dividend, LATENCY)), "remainder by zero not the dividend")

endmodule

bind signed_unsigned_divider_32_top sud_checker u_sud_checker (.*);
